>>> rtl/pidsc_pkg.sv
package pidsc_pkg;

	localparam int ERR_W  = 32;
	localparam int CAP_W  = 31;
	localparam int GAIN_W = 24;
	localparam int IDX_W  = 3;
	localparam int PROD_W = GAIN_W + 1 + ERR_W + 1;
	localparam int ACC_W  = PROD_W + 1;
	localparam int FRAC_W = 16;
	localparam int SH_W   = ACC_W - FRAC_W;

	localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [IDX_W-1:0] REG_ERR_TOL    = 3'd3;
	localparam logic [IDX_W-1:0] REG_INTEG_ZONE = 3'd4;
	localparam logic [IDX_W-1:0] REG_INTEG_LIM  = 3'd5;
	localparam logic [IDX_W-1:0] REG_MIN_DRIVE  = 3'd6;

	localparam logic [CAP_W-1:0] INTEG_LIM_RESET = {CAP_W{1'b1}};

	typedef struct packed {
		logic [GAIN_W-1:0] prop_gain;
		logic [GAIN_W-1:0] integ_gain;
		logic [GAIN_W-1:0] deriv_gain;
		logic [CAP_W-1:0]  error_tolerance;
		logic [CAP_W-1:0]  integ_zone;
		logic [CAP_W-1:0]  integ_limit;
		logic [CAP_W-1:0]  min_drive;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		prop_gain:       '0,
		integ_gain:      '0,
		deriv_gain:      '0,
		error_tolerance: '0,
		integ_zone:      '0,
		integ_limit:     INTEG_LIM_RESET,
		min_drive:       '0
	};

	// Load strobes, one per register stage; each is high only when a valid word moves in.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic so;
	} stage_ld_t;

	typedef struct packed {
		logic signed [ERR_W-1:0] err;
		logic [ERR_W-1:0]        abs_err;
		logic [CAP_W-1:0]        cap;
	} err_word_t;

	typedef struct packed {
		logic                    in_tol;
		logic signed [ERR_W-1:0] err;
		logic signed [ERR_W-1:0] integ;
		logic signed [ERR_W:0]   deriv;
		logic [CAP_W-1:0]        cap;
	} law_word_t;

	typedef struct packed {
		logic                    in_tol;
		logic signed [ACC_W-1:0] acc;
		logic [CAP_W-1:0]        cap;
	} acc_word_t;

endpackage

>>> rtl/pidsc_cfg.sv
module pidsc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pidsc_pkg::IDX_W-1:0]     cfg_index,
	input  logic [pidsc_pkg::CAP_W-1:0]     cfg_data,
	output pidsc_pkg::cfg_t                 cfg
);
	import pidsc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PROP_GAIN:  cfg_q.prop_gain       <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN: cfg_q.integ_gain      <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN: cfg_q.deriv_gain      <= cfg_data[GAIN_W-1:0];
				REG_ERR_TOL:    cfg_q.error_tolerance <= cfg_data;
				REG_INTEG_ZONE: cfg_q.integ_zone      <= cfg_data;
				REG_INTEG_LIM:  cfg_q.integ_limit     <= cfg_data;
				REG_MIN_DRIVE:  cfg_q.min_drive       <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/pidsc_front.sv
module pidsc_front (
	input  logic                            clk,
	input  pidsc_pkg::stage_ld_t            ld,
	input  logic [pidsc_pkg::ERR_W-1:0]     target_value,
	input  logic [pidsc_pkg::ERR_W-1:0]     feedback_value,
	input  logic [pidsc_pkg::CAP_W-1:0]     speed_cap,
	output pidsc_pkg::err_word_t            word_s2
);
	import pidsc_pkg::*;

	logic signed [ERR_W-1:0] tgt_s1;
	logic signed [ERR_W-1:0] fb_s1;
	logic [CAP_W-1:0]        cap_s1;
	logic signed [ERR_W:0]   diff;
	logic signed [ERR_W-1:0] err_sat;
	err_word_t               word_d;

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			tgt_s1 <= target_value;
			fb_s1  <= feedback_value;
			cap_s1 <= speed_cap;
		end
	end

	always_comb begin
		diff = tgt_s1 - fb_s1;
		// The two top bits differ only when the difference left the 32-bit range.
		if (diff[ERR_W] != diff[ERR_W-1]) begin
			err_sat = diff[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
		end else begin
			err_sat = diff[ERR_W-1:0];
		end
		word_d.err     = err_sat;
		word_d.abs_err = err_sat[ERR_W-1] ? (~err_sat + 1'b1) : err_sat;
		word_d.cap     = cap_s1;
	end

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			word_s2 <= word_d;
		end
	end

endmodule

>>> rtl/pidsc_integ.sv
module pidsc_integ (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pidsc_pkg::stage_ld_t ld,
	input  pidsc_pkg::cfg_t      cfg,
	input  pidsc_pkg::err_word_t word_s2,
	output pidsc_pkg::law_word_t word_s3
);
	import pidsc_pkg::*;

	logic signed [ERR_W-1:0] integral_q;
	logic signed [ERR_W-1:0] prev_err_q;
	logic                    in_tol;
	logic                    in_zone;
	logic signed [ERR_W:0]   sum;
	logic signed [ERR_W:0]   lim;
	logic signed [ERR_W:0]   clamped;
	logic signed [ERR_W-1:0] integ_new;
	law_word_t               word_d;

	always_comb begin
		in_tol  = word_s2.abs_err <= {1'b0, cfg.error_tolerance};
		in_zone = word_s2.abs_err < {1'b0, cfg.integ_zone};
		sum     = $signed(integral_q) + $signed(word_s2.err);
		lim     = $signed({2'b00, cfg.integ_limit});
		if (sum > lim) begin
			clamped = lim;
		end else if (sum < -lim) begin
			clamped = -lim;
		end else begin
			clamped = sum;
		end
		// Leaving the zone clears the integral; zero is always inside the clamp.
		integ_new = in_zone ? clamped[ERR_W-1:0] : '0;

		word_d.in_tol = in_tol;
		word_d.err    = word_s2.err;
		word_d.integ  = integ_new;
		word_d.deriv  = $signed(word_s2.err) - $signed(prev_err_q);
		word_d.cap    = word_s2.cap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			prev_err_q <= '0;
		end else if (ld.s3) begin
			prev_err_q <= word_s2.err;
			if (!in_tol) begin
				integral_q <= integ_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			word_s3 <= word_d;
		end
	end

endmodule

>>> rtl/pidsc_gain.sv
module pidsc_gain (
	input  logic                 clk,
	input  pidsc_pkg::stage_ld_t ld,
	input  pidsc_pkg::cfg_t      cfg,
	input  pidsc_pkg::law_word_t word_s3,
	output pidsc_pkg::acc_word_t word_s5
);
	import pidsc_pkg::*;

	logic signed [PROD_W-1:0] p_prop_s4;
	logic signed [PROD_W-1:0] p_integ_s4;
	logic signed [PROD_W-1:0] p_deriv_s4;
	logic                     inside_s4;
	logic [CAP_W-1:0]         cap_s4;
	logic signed [PROD_W-1:0] p_prop;
	logic signed [PROD_W-1:0] p_integ;
	logic signed [PROD_W-1:0] p_deriv;
	logic signed [ACC_W-1:0]  acc;

	// Gains are unsigned, so a zero sign bit goes in front before the signed multiply.
	assign p_prop  = $signed({1'b0, cfg.prop_gain}) * $signed(word_s3.err);
	assign p_integ = $signed({1'b0, cfg.integ_gain}) * $signed(word_s3.integ);
	assign p_deriv = $signed({1'b0, cfg.deriv_gain}) * $signed(word_s3.deriv);

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			p_prop_s4  <= p_prop;
			p_integ_s4 <= p_integ;
			p_deriv_s4 <= p_deriv;
			inside_s4  <= word_s3.in_tol;
			cap_s4     <= word_s3.cap;
		end
	end

	assign acc = $signed(p_prop_s4) + $signed(p_integ_s4) + $signed(p_deriv_s4);

	always_ff @(posedge clk) begin
		if (ld.s5) begin
			word_s5.in_tol <= inside_s4;
			word_s5.acc    <= acc;
			word_s5.cap    <= cap_s4;
		end
	end

endmodule

>>> rtl/pidsc_drive.sv
module pidsc_drive (
	input  logic                            clk,
	input  pidsc_pkg::stage_ld_t            ld,
	input  pidsc_pkg::cfg_t                 cfg,
	input  pidsc_pkg::acc_word_t            word_s5,
	output logic [pidsc_pkg::ERR_W-1:0]     drive_out,
	output logic                            in_tolerance
);
	import pidsc_pkg::*;

	logic signed [SH_W-1:0]  sh;
	logic signed [SH_W-1:0]  cap_x;
	logic signed [ERR_W-1:0] cap32;
	logic signed [ERR_W-1:0] clp;
	logic signed [ERR_W-1:0] mind;
	logic signed [ERR_W-1:0] speed;
	logic [ERR_W-1:0]        drive_q;
	logic                    in_tol_q;

	always_comb begin
		// Dropping the low fraction bits of a two's complement word rounds toward minus infinity.
		sh    = word_s5.acc[ACC_W-1:FRAC_W];
		cap_x = $signed({{(SH_W-CAP_W){1'b0}}, word_s5.cap});
		cap32 = $signed({1'b0, word_s5.cap});
		mind  = $signed({1'b0, cfg.min_drive});
		if (sh > cap_x) begin
			clp = cap32;
		end else if (sh < -cap_x) begin
			clp = -cap32;
		end else begin
			clp = sh[ERR_W-1:0];
		end
		// The minimum drive is applied after the cap and may exceed it.
		if (clp > 0 && clp < mind) begin
			speed = mind;
		end else if (clp < 0 && clp > -mind) begin
			speed = -mind;
		end else begin
			speed = clp;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.so) begin
			drive_q  <= word_s5.in_tol ? '0 : speed;
			in_tol_q <= word_s5.in_tol;
		end
	end

	assign drive_out    = drive_q;
	assign in_tolerance = in_tol_q;

endmodule

>>> rtl/pid_speed_controller_unit.sv
// PID speed controller with deadband, integral zone and integral clamp.
// Input words arrive on s_axis: tdata carries target, feedback and speed cap,
// all Q16.16. One result word per input leaves on m_axis: tdata is the drive
// in signed Q16.16 and tuser is set when the error was within tolerance.
// Gains, tolerance, integral zone and limit, and minimum drive are written
// through the cfg port (index 0 to 6, other indexes ignored); write them
// only while no word is in flight.
// The datapath is six register stages: input register, error, integral and
// derivative update, gain multiplies, sum, and the output clamp register.
// An accepted word passes through the stages in order to m_axis; throughput
// is one word per clock unless m_axis stalls. The integral and last-error
// state is updated in a single stage, so consecutive words see each other's
// state. Each stage holds a valid bit and takes a new word when it is empty
// or its successor is moving, so a stalled m_axis only stops s_axis once all
// six stages are full.
// Reset clears valid bits, the integral, the last error and the config registers
// (integral limit resets to its maximum).
module pid_speed_controller_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // target_value[31:0], feedback_value[63:32], speed_cap[94:64], zero[95]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // drive_out[31:0]
	output logic        m_axis_tuser,  // in_tolerance[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [30:0] cfg_data
);
	import pidsc_pkg::*;

	cfg_t      cfg;
	stage_ld_t ld;
	err_word_t word_s2;
	law_word_t word_s3;
	acc_word_t word_s5;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_o;

	assign rdy_o  = !out_valid_q || m_axis_tready;
	assign rdy_s5 = !v_s5 || rdy_o;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign ld.s1 = rdy_s1 && s_axis_tvalid;
	assign ld.s2 = rdy_s2 && v_s1;
	assign ld.s3 = rdy_s3 && v_s2;
	assign ld.s4 = rdy_s4 && v_s3;
	assign ld.s5 = rdy_s5 && v_s4;
	assign ld.so = rdy_o && v_s5;

	assign s_axis_tready = rdy_s1;
	assign m_axis_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_axis_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_o)  out_valid_q <= v_s5;
		end
	end

	pidsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidsc_front u_front (
		.clk            (clk),
		.ld             (ld),
		.target_value   (s_axis_tdata[31:0]),
		.feedback_value (s_axis_tdata[63:32]),
		.speed_cap      (s_axis_tdata[94:64]),
		.word_s2        (word_s2)
	);

	pidsc_integ u_integ (
		.clk     (clk),
		.arst_n  (arst_n),
		.ld      (ld),
		.cfg     (cfg),
		.word_s2 (word_s2),
		.word_s3 (word_s3)
	);

	pidsc_gain u_gain (
		.clk     (clk),
		.ld      (ld),
		.cfg     (cfg),
		.word_s3 (word_s3),
		.word_s5 (word_s5)
	);

	pidsc_drive u_drive (
		.clk          (clk),
		.ld           (ld),
		.cfg          (cfg),
		.word_s5      (word_s5),
		.drive_out    (m_axis_tdata),
		.in_tolerance (m_axis_tuser)
	);

endmodule
